// ===== sv/smx_pkg.sv =====
`timescale 1ns / 1ps
package smx_pkg;

  localparam int unsigned MemWords  = 512;
  localparam int unsigned LevelMax  = 15;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned PcSpan    = 512;

  localparam logic [3:0] OP_LIT = 4'd1;
  localparam logic [3:0] OP_OPR = 4'd2;
  localparam logic [3:0] OP_LOD = 4'd3;
  localparam logic [3:0] OP_STO = 4'd4;
  localparam logic [3:0] OP_CAL = 4'd5;
  localparam logic [3:0] OP_INC = 4'd6;
  localparam logic [3:0] OP_JMP = 4'd7;
  localparam logic [3:0] OP_JPC = 4'd8;
  localparam logic [3:0] OP_SYS = 4'd9;

  localparam logic signed [31:0] FN_RTN = 32'sd0;
  localparam logic signed [31:0] FN_ADD = 32'sd1;
  localparam logic signed [31:0] FN_SUB = 32'sd2;
  localparam logic signed [31:0] FN_MUL = 32'sd3;
  localparam logic signed [31:0] FN_DIV = 32'sd4;
  localparam logic signed [31:0] FN_EQL = 32'sd5;
  localparam logic signed [31:0] FN_NEQ = 32'sd6;
  localparam logic signed [31:0] FN_LSS = 32'sd7;
  localparam logic signed [31:0] FN_LEQ = 32'sd8;
  localparam logic signed [31:0] FN_GTR = 32'sd9;
  localparam logic signed [31:0] FN_GEQ = 32'sd10;

  localparam logic signed [31:0] SYS_WRITE = 32'sd1;
  localparam logic signed [31:0] SYS_READ  = 32'sd2;
  localparam logic signed [31:0] SYS_HALT  = 32'sd3;

  localparam logic [1:0] FLT_NONE  = 2'd0;
  localparam logic [1:0] FLT_DIV0  = 2'd1;
  localparam logic [1:0] FLT_RANGE = 2'd2;
  localparam logic [1:0] FLT_BADOP = 2'd3;

  localparam logic REG_STACK_BASE = 1'b0;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_WALK, S_WALK_D, S_PLAN, S_RD1, S_RD2,
    S_CAP, S_COMP, S_DIV, S_WR, S_FIN, S_TOP, S_TOP_D
  } state_e;

  typedef logic signed [33:0] wide_t;

endpackage

// ===== sv/stack_machine_execute_unit.sv =====
`timescale 1ns / 1ps
// channel | direction | handshake                 | payload
// in      | input     | in_valid_i / in_stall_o   | opcode, level, operand_m, read_value
// out     | output    | out_valid_o / out_stall_i | pc, pointers, top, print, halted, fault
// cfg     | input     | psel penable pwrite pready| stack_base at byte address 0
// one word at a time through a sequencer around a single-port stack memory
// after reset a clearing pass over all 512 addresses zeroes the stack memory before any word
// the next word is taken while a result still waits in the output register
module stack_machine_execute_unit
  import smx_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [3:0]         opcode_i,
  input  logic [3:0]         level_i,
  input  logic signed [31:0] operand_m_i,
  input  logic signed [31:0] read_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [8:0]         next_pc_o,
  output logic [8:0]         base_ptr_o,
  output logic signed [9:0]  stack_ptr_o,
  output logic signed [31:0] top_value_o,
  output logic               print_valid_o,
  output logic signed [31:0] print_value_o,
  output logic               halted_o,
  output logic [1:0]         fault_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  state_e state_q, state_d;

  logic [31:0] mem [MemWords];
  logic [31:0] rdata_q;
  logic        mem_we, mem_re;
  logic [8:0]  mem_addr;
  logic [31:0] mem_wdata;

  logic [8:0]         base_q, pc_q, bp_q;
  logic signed [9:0]  sp_q;
  logic               halt_q;
  logic [8:0]         clr_q;

  logic [3:0]         op_q, cnt_q;
  logic signed [31:0] m_q, rv_q, x_q, y_q;
  wide_t              a_q;
  logic [1:0]         fault_q, nr_q, wn_q, wi_q;
  logic [8:0]         r1_q, r2_q, addr_q, npc_q, nbp_q;
  logic signed [9:0]  nsp_q;
  logic               nhalt_q, pvalid_q;
  logic signed [31:0] pv_q;
  logic [8:0]         wa_q [3];
  logic [31:0]        wd_q [3];

  logic [31:0] dq_q, dd_q;
  logic [32:0] dr_q;
  logic [4:0]  dcnt_q;
  logic        dneg_q;

  logic               ov_q, opv_q, ohalt_q;
  logic [8:0]         opc_q, obp_q;
  logic signed [9:0]  osp_q;
  logic signed [31:0] otop_q, opvv_q;
  logic [1:0]         ofault_q;

  logic cfg_wr;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_STACK_BASE);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_STACK_BASE) ? {23'b0, base_q} : 32'b0;

  function automatic logic in_mem(wide_t v);
    return (v >= 0) && (v < wide_t'(MemWords));
  endfunction

  function automatic logic in_pc(wide_t v);
    return (v >= 0) && (v < wide_t'(PcSpan));
  endfunction

  wide_t sp_w, bp_w, m_w, addr_w;
  assign sp_w   = {{24{sp_q[9]}}, sp_q};
  assign bp_w   = {25'b0, bp_q};
  assign m_w    = {{2{m_q[31]}}, m_q};
  assign addr_w = a_q + m_w;

  // decode and range checks before any memory read
  logic [1:0] p_fault, p_nr;
  logic [8:0] p_r1, p_r2;
  always_comb begin
    p_fault = FLT_NONE;
    p_nr    = 2'd0;
    p_r1    = '0;
    p_r2    = '0;
    case (op_q)
      OP_LIT: if (!in_mem(sp_w + 1)) p_fault = FLT_RANGE;
      OP_OPR: begin
        if (m_q == FN_RTN) begin
          if (!in_mem(bp_w + 1) || !in_mem(bp_w + 2)) p_fault = FLT_RANGE;
          p_r1 = 9'(bp_w + 1);
          p_r2 = 9'(bp_w + 2);
          p_nr = 2'd2;
        end else if (m_q >= FN_ADD && m_q <= FN_GEQ) begin
          if (!in_mem(sp_w) || !in_mem(sp_w - 1)) p_fault = FLT_RANGE;
          p_r1 = 9'(sp_w - 1);
          p_r2 = sp_q[8:0];
          p_nr = 2'd2;
        end else begin
          p_fault = FLT_BADOP;
        end
      end
      OP_LOD: begin
        if (!in_mem(addr_w) || !in_mem(sp_w + 1)) p_fault = FLT_RANGE;
        p_r1 = addr_w[8:0];
        p_nr = 2'd1;
      end
      OP_STO: begin
        if (!in_mem(addr_w) || !in_mem(sp_w)) p_fault = FLT_RANGE;
        p_r1 = sp_q[8:0];
        p_nr = 2'd1;
      end
      OP_CAL: begin
        if (!in_mem(sp_w + 1) || !in_mem(sp_w + 3) || !in_pc(m_w)) p_fault = FLT_RANGE;
      end
      OP_INC: ;
      OP_JMP: if (!in_pc(m_w)) p_fault = FLT_RANGE;
      OP_JPC: begin
        if (!in_mem(sp_w)) p_fault = FLT_RANGE;
        p_r1 = sp_q[8:0];
        p_nr = 2'd1;
      end
      OP_SYS: begin
        case (m_q)
          SYS_WRITE: begin
            if (!in_mem(sp_w)) p_fault = FLT_RANGE;
            p_r1 = sp_q[8:0];
            p_nr = 2'd1;
          end
          SYS_READ: if (!in_mem(sp_w + 1)) p_fault = FLT_RANGE;
          SYS_HALT: ;
          default:  p_fault = FLT_BADOP;
        endcase
      end
      default: p_fault = FLT_BADOP;
    endcase
  end

  // results once the operands are in
  logic [1:0]         c_fault, c_wn;
  logic [8:0]         c_wa [3];
  logic [31:0]        c_wd [3];
  wide_t              c_nsp, c_rnbp, c_rnpc;
  logic [8:0]         c_npc, c_nbp;
  logic               c_pvalid, c_halt, c_div;
  logic signed [31:0] c_pv;
  logic [63:0]        prod;
  assign prod   = 64'(x_q) * 64'(y_q);
  assign c_rnbp = {{2{x_q[31]}}, x_q};
  assign c_rnpc = {{2{y_q[31]}}, y_q};

  always_comb begin
    c_fault  = fault_q;
    c_wn     = 2'd0;
    c_wa[0]  = '0;
    c_wa[1]  = '0;
    c_wa[2]  = '0;
    c_wd[0]  = '0;
    c_wd[1]  = '0;
    c_wd[2]  = '0;
    c_nsp    = sp_w;
    c_npc    = npc_q;
    c_nbp    = bp_q;
    c_pvalid = 1'b0;
    c_pv     = '0;
    c_halt   = 1'b0;
    c_div    = 1'b0;
    case (op_q)
      OP_LIT: begin
        c_wn = 2'd1; c_wa[0] = 9'(sp_w + 1); c_wd[0] = m_q; c_nsp = sp_w + 1;
      end
      OP_OPR: begin
        if (m_q == FN_RTN) begin
          c_nbp = c_rnbp[8:0];
          c_npc = c_rnpc[8:0];
          c_nsp = bp_w - 1;
          if (!in_mem(c_rnbp) || !in_pc(c_rnpc)) c_fault = FLT_RANGE;
        end else begin
          c_wn    = 2'd1;
          c_wa[0] = 9'(sp_w - 1);
          c_nsp   = sp_w - 1;
          case (m_q)
            FN_ADD: c_wd[0] = x_q + y_q;
            FN_SUB: c_wd[0] = x_q - y_q;
            FN_MUL: c_wd[0] = prod[31:0];
            FN_DIV: begin
              if (y_q == 0) c_fault = FLT_DIV0;
              else c_div = 1'b1;
            end
            FN_EQL: c_wd[0] = {31'b0, x_q == y_q};
            FN_NEQ: c_wd[0] = {31'b0, x_q != y_q};
            FN_LSS: c_wd[0] = {31'b0, x_q < y_q};
            FN_LEQ: c_wd[0] = {31'b0, x_q <= y_q};
            FN_GTR: c_wd[0] = {31'b0, x_q > y_q};
            default: c_wd[0] = {31'b0, x_q >= y_q};
          endcase
        end
      end
      OP_LOD: begin
        c_wn = 2'd1; c_wa[0] = 9'(sp_w + 1); c_wd[0] = x_q; c_nsp = sp_w + 1;
      end
      OP_STO: begin
        c_wn = 2'd1; c_wa[0] = addr_q; c_wd[0] = x_q; c_nsp = sp_w - 1;
      end
      OP_CAL: begin
        c_wn    = 2'd3;
        c_wa[0] = 9'(sp_w + 1); c_wd[0] = a_q[31:0];
        c_wa[1] = 9'(sp_w + 2); c_wd[1] = {23'b0, bp_q};
        c_wa[2] = 9'(sp_w + 3); c_wd[2] = {23'b0, npc_q};
        c_nbp   = 9'(sp_w + 1);
        c_npc   = m_q[8:0];
      end
      OP_INC: c_nsp = sp_w + m_w;
      OP_JMP: c_npc = m_q[8:0];
      OP_JPC: begin
        if (x_q == 0) begin
          if (!in_pc(m_w)) c_fault = FLT_RANGE;
          c_npc = m_q[8:0];
        end
        c_nsp = sp_w - 1;
      end
      OP_SYS: begin
        case (m_q)
          SYS_WRITE: begin
            c_pvalid = 1'b1; c_pv = x_q; c_nsp = sp_w - 1;
          end
          SYS_READ: begin
            c_wn = 2'd1; c_wa[0] = 9'(sp_w + 1); c_wd[0] = rv_q; c_nsp = sp_w + 1;
          end
          default: c_halt = 1'b1;
        endcase
      end
      default: ;
    endcase
    if (c_fault <= FLT_DIV0 && (c_nsp < -1 || c_nsp > wide_t'(MemWords - 1))) begin
      c_fault = FLT_RANGE;
    end
    if (c_fault > FLT_DIV0) begin
      c_wn  = 2'd0;
      c_div = 1'b0;
    end
  end

  // restoring divider step on magnitudes
  logic [32:0] d_sh, d_sub;
  logic        d_bit;
  logic [31:0] d_q_next, d_res;
  assign d_sh     = {dr_q[31:0], dq_q[31]};
  assign d_sub    = d_sh - {1'b0, dd_q};
  assign d_bit    = (d_sh >= {1'b0, dd_q});
  assign d_q_next = {dq_q[30:0], d_bit};
  assign d_res    = dneg_q ? (32'b0 - d_q_next) : d_q_next;

  logic in_acc, out_load;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_load   = (state_q == S_TOP_D) & (~ov_q | ~out_stall_i);

  always_comb begin
    state_d   = state_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = '0;
    mem_wdata = '0;
    unique case (state_q)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
        if (clr_q == 9'(MemWords - 1)) state_d = S_IDLE;
      end
      S_IDLE: if (in_acc) state_d = S_EXEC;
      S_EXEC: begin
        if (halt_q) state_d = S_FIN;
        else if (op_q == OP_LOD || op_q == OP_STO || op_q == OP_CAL) begin
          state_d = ({28'b0, cnt_q} > LevelMax) ? S_FIN : S_WALK;
        end else state_d = S_PLAN;
      end
      S_WALK: begin
        if (cnt_q == 4'd0) state_d = S_PLAN;
        else if (!in_mem(a_q)) state_d = S_FIN;
        else begin
          mem_re   = 1'b1;
          mem_addr = a_q[8:0];
          state_d  = S_WALK_D;
        end
      end
      S_WALK_D: state_d = S_WALK;
      S_PLAN: begin
        if (p_fault != FLT_NONE) state_d = S_FIN;
        else if (p_nr == 2'd0) state_d = S_COMP;
        else state_d = S_RD1;
      end
      S_RD1: begin
        mem_re   = 1'b1;
        mem_addr = r1_q;
        state_d  = S_RD2;
      end
      S_RD2: begin
        if (nr_q == 2'd2) begin
          mem_re   = 1'b1;
          mem_addr = r2_q;
          state_d  = S_CAP;
        end else state_d = S_COMP;
      end
      S_CAP: state_d = S_COMP;
      S_COMP: state_d = c_div ? S_DIV : S_WR;
      S_DIV: if (dcnt_q == 5'd31) state_d = S_WR;
      S_WR: begin
        if (wi_q == wn_q) state_d = S_FIN;
        else begin
          mem_we    = 1'b1;
          mem_addr  = wa_q[wi_q];
          mem_wdata = wd_q[wi_q];
        end
      end
      S_FIN: state_d = S_TOP;
      S_TOP: begin
        if (in_mem(sp_w)) begin
          mem_re   = 1'b1;
          mem_addr = sp_q[8:0];
        end
        state_d = S_TOP_D;
      end
      S_TOP_D: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLEAR;
    else state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      base_q  <= '0;
      pc_q    <= '0;
      bp_q    <= '0;
      sp_q    <= -10'sd1;
      halt_q  <= 1'b0;
      ov_q    <= 1'b0;
      fault_q <= FLT_NONE;
      wi_q    <= '0;
      wn_q    <= '0;
    end else begin
      if (state_q == S_CLEAR) clr_q <= clr_q + 9'd1;
      if (state_q == S_FIN) begin
        if (fault_q <= FLT_DIV0) begin
          pc_q <= npc_q;
          bp_q <= nbp_q;
          sp_q <= nsp_q;
          if (nhalt_q) halt_q <= 1'b1;
        end else begin
          pc_q <= pc_q + 9'd3;
        end
      end
      if (cfg_wr) begin
        base_q <= pwdata[8:0];
        bp_q   <= pwdata[8:0];
        sp_q   <= $signed({1'b0, pwdata[8:0]}) - 10'sd1;
      end
      if (out_load) ov_q <= 1'b1;
      else if (ov_q && !out_stall_i) ov_q <= 1'b0;
      case (state_q)
        S_IDLE: if (in_acc) begin
          fault_q <= FLT_NONE;
          wi_q    <= '0;
          wn_q    <= '0;
        end
        S_WALK: if (cnt_q != 4'd0 && !in_mem(a_q)) fault_q <= FLT_RANGE;
        S_EXEC: if (!halt_q && (op_q == OP_LOD || op_q == OP_STO || op_q == OP_CAL) &&
                    ({28'b0, cnt_q} > LevelMax)) fault_q <= FLT_RANGE;
        S_PLAN: fault_q <= p_fault;
        S_COMP: begin
          fault_q <= c_fault;
          wn_q    <= c_wn;
        end
        S_WR: if (wi_q != wn_q) wi_q <= wi_q + 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: if (in_acc) begin
        op_q     <= opcode_i;
        cnt_q    <= level_i;
        m_q      <= operand_m_i;
        rv_q     <= read_value_i;
        a_q      <= bp_w;
        npc_q    <= pc_q + 9'd3;
        nbp_q    <= bp_q;
        nsp_q    <= sp_q;
        nhalt_q  <= 1'b0;
        pvalid_q <= 1'b0;
        pv_q     <= '0;
      end
      S_EXEC: if (halt_q) npc_q <= pc_q;
      S_WALK_D: begin
        a_q   <= {{2{rdata_q[31]}}, rdata_q};
        cnt_q <= cnt_q - 4'd1;
      end
      S_PLAN: begin
        nr_q   <= p_nr;
        r1_q   <= p_r1;
        r2_q   <= p_r2;
        addr_q <= addr_w[8:0];
      end
      S_RD2: x_q <= rdata_q;
      S_CAP: y_q <= rdata_q;
      S_COMP: begin
        wa_q     <= c_wa;
        wd_q     <= c_wd;
        npc_q    <= c_npc;
        nbp_q    <= c_nbp;
        nsp_q    <= c_nsp[9:0];
        pvalid_q <= c_pvalid;
        pv_q     <= c_pv;
        nhalt_q  <= c_halt;
        dq_q     <= x_q[31] ? (32'b0 - x_q) : x_q;
        dd_q     <= y_q[31] ? (32'b0 - y_q) : y_q;
        dr_q     <= '0;
        dcnt_q   <= '0;
        dneg_q   <= x_q[31] ^ y_q[31];
      end
      S_DIV: begin
        dq_q   <= d_q_next;
        dr_q   <= d_bit ? d_sub : d_sh;
        dcnt_q <= dcnt_q + 5'd1;
        if (dcnt_q == 5'd31) wd_q[0] <= d_res;
      end
      S_FIN: if (fault_q > FLT_DIV0) begin
        pvalid_q <= 1'b0;
        pv_q     <= '0;
      end
      default: ;
    endcase
    if (out_load) begin
      opc_q    <= pc_q;
      obp_q    <= bp_q;
      osp_q    <= sp_q;
      otop_q   <= in_mem(sp_w) ? rdata_q : 32'sd0;
      opv_q    <= pvalid_q;
      opvv_q   <= pvalid_q ? pv_q : 32'sd0;
      ohalt_q  <= halt_q;
      ofault_q <= fault_q;
    end
  end

  assign out_valid_o   = ov_q;
  assign next_pc_o     = opc_q;
  assign base_ptr_o    = obp_q;
  assign stack_ptr_o   = osp_q;
  assign top_value_o   = otop_q;
  assign print_valid_o = opv_q;
  assign print_value_o = opvv_q;
  assign halted_o      = ohalt_q;
  assign fault_o       = ofault_q;

endmodule
